// ----- design/mali_pkg.sv -----
// Shared types and constants of the multi-axis linear interpolator.
`default_nettype none
package mali_pkg;

   // Width of every angle field on the ports
   localparam int FIELD_BITS = 9;
   // Number of goal and position fields on the ports
   localparam int GOAL_FIELDS = 6;
   // Largest axis count the home table covers
   localparam int MAX_AXES = 8;

   // Home pose, one entry per axis
   localparam logic [7:0] HOME_ANGLE [MAX_AXES] = '{
      8'd90, 8'd90, 8'd90, 8'd74, 8'd158, 8'd180, 8'd90, 8'd90
   };

   // Transaction kinds on the request channel
   localparam logic KIND_TARGET = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // Sequencer commands broadcast to every axis lane
   typedef struct packed {
      logic load;      // latch a new goal and its distance
      logic start;     // clear the serial carry chains before a tick
      logic p1_shift;  // remainder pass: add distance, trial-subtract length
      logic commit;    // keep or drop the trial result, arm the position step
      logic p2_shift;  // position pass: step the angle by one or zero
   } lane_ctrl_type;

   // Result handoff from the sequencer to the output register
   typedef struct packed {
      logic publish;
      logic moving;
      logic arrived;
   } rsp_info_type;

endpackage
`default_nettype wire

// ----- design/multi_axis_linear_interpolator.sv -----
// Top level of the coordinated multi-axis linear move interpolator.
// A target transaction (kind 0) takes the present pose as the start, the given angles
// as the goal and the largest axis distance as the move length, found by a scan over
// the axes, one per cycle. A tick transaction (kind 1) during a move runs two
// bit-serial passes in every axis lane, all lanes in parallel: one pass adds the axis
// distance to a running remainder and trial-subtracts the length, the other steps the
// angle by one degree when the remainder wrapped. This keeps each angle exactly at
// start + (goal - start) * step / length, truncated toward zero. A tick outside a move
// repeats the present pose. Each transaction gives one result, held in an output
// register so the next request is taken while it waits.
`default_nettype none
module multi_axis_linear_interpolator #(
   parameter int AXES = 6,
   parameter int ANGLE_BITS = 9
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire        req_kind,
   input  wire  [8:0] req_goal_base,
   input  wire  [8:0] req_goal_arm,
   input  wire  [8:0] req_goal_wrist,
   input  wire  [8:0] req_goal_top,
   input  wire  [8:0] req_goal_middle,
   input  wire  [8:0] req_goal_lower,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [8:0] rsp_pos_base,
   output logic [8:0] rsp_pos_arm,
   output logic [8:0] rsp_pos_wrist,
   output logic [8:0] rsp_pos_top,
   output logic [8:0] rsp_pos_middle,
   output logic [8:0] rsp_pos_lower,
   output logic       rsp_moving,
   output logic       rsp_arrived
);

   localparam int FIELD_W = mali_pkg::FIELD_BITS;
   localparam int FIELDS  = mali_pkg::GOAL_FIELDS;

   mali_pkg::lane_ctrl_type          ctrl;
   mali_pkg::rsp_info_type           info;
   logic                             len_bit;
   logic                             slot_free;
   logic [AXES-1:0][ANGLE_BITS-1:0]  pos_all;
   logic [AXES-1:0][ANGLE_BITS-1:0]  diff_all;
   logic [FIELD_W-1:0]               goal_field [FIELDS];
   logic [FIELD_W-1:0]               pos_field  [FIELDS];

   logic                             rsp_valid_ff;
   logic [FIELD_W-1:0]               rsp_pos_ff [FIELDS];
   logic                             rsp_moving_ff;
   logic                             rsp_arrived_ff;

   assign goal_field[0] = req_goal_base;
   assign goal_field[1] = req_goal_arm;
   assign goal_field[2] = req_goal_wrist;
   assign goal_field[3] = req_goal_top;
   assign goal_field[4] = req_goal_middle;
   assign goal_field[5] = req_goal_lower;

   // Sequence the move and drive the lanes
   mali_seq #(
      .AXES       (AXES),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_kind    (req_kind),
      .req_ready   (req_ready),
      .diff_i      (diff_all),
      .slot_free_i (slot_free),
      .ctrl_o      (ctrl),
      .len_bit_o   (len_bit),
      .info_o      (info)
   );

   // One lane per axis; axes without a goal field keep their present angle as goal
   for (genvar i = 0; i < AXES; i++) begin : g_lane
      logic [ANGLE_BITS-1:0] goal;
      if (i < FIELDS) begin : g_field
         assign goal = ANGLE_BITS'(goal_field[i]);
      end else begin : g_hold
         assign goal = pos_all[i];
      end
      mali_lane #(
         .ANGLE_BITS (ANGLE_BITS),
         .HOME       (mali_pkg::HOME_ANGLE[i])
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl_i    (ctrl),
         .goal_i    (goal),
         .len_bit_i (len_bit),
         .pos_o     (pos_all[i]),
         .diff_o    (diff_all[i])
      );
   end

   // Map lane angles to result fields; positions without an axis read zero
   for (genvar i = 0; i < FIELDS; i++) begin : g_out
      if (i < AXES) begin : g_axis
         assign pos_field[i] = FIELD_W'(pos_all[i]);
      end else begin : g_none
         assign pos_field[i] = '0;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (info.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (info.publish) begin
         rsp_pos_ff     <= pos_field;
         rsp_moving_ff  <= info.moving;
         rsp_arrived_ff <= info.arrived;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_base   = rsp_pos_ff[0];
   assign rsp_pos_arm    = rsp_pos_ff[1];
   assign rsp_pos_wrist  = rsp_pos_ff[2];
   assign rsp_pos_top    = rsp_pos_ff[3];
   assign rsp_pos_middle = rsp_pos_ff[4];
   assign rsp_pos_lower  = rsp_pos_ff[5];
   assign rsp_moving     = rsp_moving_ff;
   assign rsp_arrived    = rsp_arrived_ff;

endmodule
`default_nettype wire

// ----- design/mali_lane.sv -----
// One axis lane: bit-serial remainder update and position step.
`default_nettype none
module mali_lane #(
   parameter int ANGLE_BITS = 9,
   parameter logic [7:0] HOME = 8'd90
) (
   input  wire                          clock,
   input  wire                          reset,
   input  mali_pkg::lane_ctrl_type      ctrl_i,
   input  wire  [ANGLE_BITS-1:0]        goal_i,
   input  wire                          len_bit_i,
   output logic [ANGLE_BITS-1:0]        pos_o,
   output logic [ANGLE_BITS-1:0]        diff_o
);

   logic [ANGLE_BITS-1:0] pos_ff, pos_in;
   logic [ANGLE_BITS-1:0] diff_ff, diff_in;
   logic [ANGLE_BITS-1:0] rem_ff, rem_in;
   logic [ANGLE_BITS-1:0] trial_ff, trial_in;
   logic                  up_ff, up_in;
   logic                  carry_ff, carry_in;
   logic                  borrow_ff, borrow_in;

   logic sum_bit, sum_carry, trial_bit, trial_borrow, take, pos_bit;

   // Serial add of distance into remainder, and trial subtract of the length
   always_comb begin
      sum_bit      = rem_ff[0] ^ diff_ff[0] ^ carry_ff;
      sum_carry    = (rem_ff[0] & diff_ff[0]) | (rem_ff[0] & carry_ff) |
                     (diff_ff[0] & carry_ff);
      trial_bit    = sum_bit ^ len_bit_i ^ borrow_ff;
      trial_borrow = (~sum_bit & len_bit_i) | (~sum_bit & borrow_ff) |
                     (len_bit_i & borrow_ff);
      // Sum reached the length when it overflowed or the subtract did not borrow
      take         = carry_ff | ~borrow_ff;
      pos_bit      = pos_ff[0] ^ carry_ff;
   end

   // Next state of the lane
   always_comb begin
      pos_in    = pos_ff;
      diff_in   = diff_ff;
      rem_in    = rem_ff;
      trial_in  = trial_ff;
      up_in     = up_ff;
      carry_in  = carry_ff;
      borrow_in = borrow_ff;
      if (ctrl_i.load) begin
         up_in   = goal_i >= pos_ff;
         diff_in = (goal_i >= pos_ff) ? goal_i - pos_ff : pos_ff - goal_i;
         rem_in  = '0;
      end
      if (ctrl_i.start) begin
         carry_in  = 1'b0;
         borrow_in = 1'b0;
      end
      if (ctrl_i.p1_shift) begin
         rem_in    = {sum_bit, rem_ff[ANGLE_BITS-1:1]};
         trial_in  = {trial_bit, trial_ff[ANGLE_BITS-1:1]};
         diff_in   = {diff_ff[0], diff_ff[ANGLE_BITS-1:1]};
         carry_in  = sum_carry;
         borrow_in = trial_borrow;
      end
      if (ctrl_i.commit) begin
         if (take) begin
            rem_in = trial_ff;
         end
         carry_in = take;
      end
      if (ctrl_i.p2_shift) begin
         pos_in   = {pos_bit, pos_ff[ANGLE_BITS-1:1]};
         carry_in = up_ff ? (pos_ff[0] & carry_ff) : (~pos_ff[0] & carry_ff);
      end
   end

   // Hold lane registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= ANGLE_BITS'(HOME);
      end else begin
         pos_ff <= pos_in;
      end
      diff_ff   <= diff_in;
      rem_ff    <= rem_in;
      trial_ff  <= trial_in;
      up_ff     <= up_in;
      carry_ff  <= carry_in;
      borrow_ff <= borrow_in;
   end

   assign pos_o  = pos_ff;
   assign diff_o = diff_ff;

endmodule
`default_nettype wire

// ----- design/mali_seq.sv -----
// Move sequencer: length scan, step counter and bit-serial pass control.
`default_nettype none
module mali_seq #(
   parameter int AXES = 6,
   parameter int ANGLE_BITS = 9
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   input  wire                                 req_kind,
   output logic                                req_ready,
   input  wire  [AXES-1:0][ANGLE_BITS-1:0]     diff_i,
   input  wire                                 slot_free_i,
   output mali_pkg::lane_ctrl_type             ctrl_o,
   output logic                                len_bit_o,
   output mali_pkg::rsp_info_type              info_o
);

   localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int BIT_W  = $clog2(ANGLE_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PASS1,
      ST_COMMIT,
      ST_PASS2,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [ANGLE_BITS-1:0] step_ff, step_in;
   logic [ANGLE_BITS-1:0] len_ff, len_in;
   logic [ANGLE_BITS-1:0] len_sh_ff, len_sh_in;
   logic [ANGLE_BITS-1:0] max_ff, max_in;
   logic [AXIS_W-1:0]     axis_ff, axis_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic                  arrived_ff, arrived_in;

   logic [ANGLE_BITS-1:0] step_inc;
   logic [ANGLE_BITS-1:0] longest;
   logic                  accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign len_bit_o = len_sh_ff[0];
   assign step_inc  = step_ff + 1'b1;
   assign longest   = (diff_i[axis_ff] > max_ff) ? diff_i[axis_ff] : max_ff;

   // Next state and lane commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      len_in     = len_ff;
      len_sh_in  = len_sh_ff;
      max_in     = max_ff;
      axis_in    = axis_ff;
      bit_in     = bit_ff;
      arrived_in = arrived_ff;
      ctrl_o     = '0;
      info_o     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == mali_pkg::KIND_TARGET) begin
                  ctrl_o.load = 1'b1;
                  max_in      = '0;
                  axis_in     = '0;
                  state_in    = ST_SCAN;
               end else if (step_ff < len_ff) begin
                  ctrl_o.start = 1'b1;
                  step_in      = step_inc;
                  arrived_in   = (step_inc == len_ff);
                  len_sh_in    = len_ff;
                  bit_in       = '0;
                  state_in     = ST_PASS1;
               end else begin
                  arrived_in = 1'b0;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            // Take the largest axis distance, one axis per cycle
            if (axis_ff == AXIS_W'(AXES - 1)) begin
               len_in     = longest;
               step_in    = '0;
               arrived_in = (longest == '0);
               state_in   = ST_DONE;
            end else begin
               max_in  = longest;
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_PASS1: begin
            ctrl_o.p1_shift = 1'b1;
            len_sh_in       = len_sh_ff >> 1;
            bit_in          = bit_ff + 1'b1;
            if (bit_ff == BIT_W'(ANGLE_BITS - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            ctrl_o.commit = 1'b1;
            bit_in        = '0;
            state_in      = ST_PASS2;
         end
         ST_PASS2: begin
            ctrl_o.p2_shift = 1'b1;
            bit_in          = bit_ff + 1'b1;
            if (bit_ff == BIT_W'(ANGLE_BITS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand the result over once the output register is free
            if (slot_free_i) begin
               info_o.publish = 1'b1;
               info_o.moving  = (step_ff < len_ff);
               info_o.arrived = arrived_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, counters and move registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         len_ff     <= '0;
         arrived_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         len_ff     <= len_in;
         arrived_ff <= arrived_in;
      end
      len_sh_ff <= len_sh_in;
      max_ff    <= max_in;
      axis_ff   <= axis_in;
      bit_ff    <= bit_in;
   end

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= len_ff)
      else $error("step counter passed the move length");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(ctrl_o.p1_shift || ctrl_o.commit || ctrl_o.p2_shift))
      else $error("lane pass active while accepting a transaction");

   a_arrived_end: assert property (@(posedge clock) disable iff (reset)
      (info_o.publish && info_o.arrived) |-> (step_ff == len_ff))
      else $error("arrival flagged before the last step");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      info_o.publish |-> !(info_o.moving && info_o.arrived))
      else $error("moving and arrived both set");

endmodule
`default_nettype wire

// ----- sim/tb_multi_axis_linear_interpolator.sv -----
// Self-checking testbench of the multi-axis linear interpolator: directed table, then random moves.
`timescale 1ns / 1ps
module tb_multi_axis_linear_interpolator;

   localparam int AXES = mali_pkg::GOAL_FIELDS;
   // Longest stretch without any transaction before the run is declared hung
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 550;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic                kind;
      logic [5:0][8:0]     goal;   // base, arm, wrist, top, middle, lower
   } motion_req_type;

   typedef struct packed {
      logic [5:0][8:0]     pos;
      logic                moving;
      logic                arrived;
   } pose_rsp_type;

   typedef struct packed {
      motion_req_type      rq;
      logic                known_rsp;
      pose_rsp_type        rsp;
   } plan_row_type;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   wire        req_ready;
   logic       req_kind = mali_pkg::KIND_TICK;
   logic [8:0] req_goal_base = '0;
   logic [8:0] req_goal_arm = '0;
   logic [8:0] req_goal_wrist = '0;
   logic [8:0] req_goal_top = '0;
   logic [8:0] req_goal_middle = '0;
   logic [8:0] req_goal_lower = '0;
   wire        rsp_valid;
   logic       rsp_ready = 1'b0;
   wire  [8:0] rsp_pos_base;
   wire  [8:0] rsp_pos_arm;
   wire  [8:0] rsp_pos_wrist;
   wire  [8:0] rsp_pos_top;
   wire  [8:0] rsp_pos_middle;
   wire  [8:0] rsp_pos_lower;
   wire        rsp_moving;
   wire        rsp_arrived;

   multi_axis_linear_interpolator u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_goal_base  (req_goal_base),
      .req_goal_arm   (req_goal_arm),
      .req_goal_wrist (req_goal_wrist),
      .req_goal_top   (req_goal_top),
      .req_goal_middle(req_goal_middle),
      .req_goal_lower (req_goal_lower),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pos_base   (rsp_pos_base),
      .rsp_pos_arm    (rsp_pos_arm),
      .rsp_pos_wrist  (rsp_pos_wrist),
      .rsp_pos_top    (rsp_pos_top),
      .rsp_pos_middle (rsp_pos_middle),
      .rsp_pos_lower  (rsp_pos_lower),
      .rsp_moving     (rsp_moving),
      .rsp_arrived    (rsp_arrived)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Interpolator state as the testbench sees it
   int start_ang [AXES];
   int goal_ang [AXES];
   int cur_ang [AXES];
   int steps_done;
   int move_len;

   pose_rsp_type pose_q [$];
   int mismatches = 0;
   int hold_asks = 0;
   int burst_left = 0;

   function automatic int lerp_angle(input int s, input int g, input int k, input int len);
      if (g >= s) return s + ((g - s) * k) / len;
      return s - ((s - g) * k) / len;
   endfunction

   // Advance the motion state by one transaction and form its result
   task automatic predict_pose(input motion_req_type rq, output pose_rsp_type rs);
      int longest;
      int d;
      logic hit;
      hit = 1'b0;
      if (rq.kind == mali_pkg::KIND_TARGET) begin
         longest = 0;
         for (int i = 0; i < AXES; i++) begin
            start_ang[i] = cur_ang[i];
            goal_ang[i] = int'(rq.goal[i]);
            d = (goal_ang[i] >= cur_ang[i]) ? goal_ang[i] - cur_ang[i]
                                            : cur_ang[i] - goal_ang[i];
            if (d > longest) longest = d;
         end
         steps_done = 0;
         move_len = longest;
         if (longest == 0) begin
            for (int i = 0; i < AXES; i++) cur_ang[i] = goal_ang[i];
            hit = 1'b1;
         end
      end else if (steps_done < move_len) begin
         steps_done++;
         for (int i = 0; i < AXES; i++)
            cur_ang[i] = lerp_angle(start_ang[i], goal_ang[i], steps_done, move_len);
         if (steps_done == move_len) hit = 1'b1;
      end
      for (int i = 0; i < AXES; i++) rs.pos[i] = cur_ang[i][8:0];
      rs.moving = (steps_done < move_len);
      rs.arrived = hit;
   endtask

   function automatic plan_row_type tgt(input logic [8:0] b, a, w, t, m, l);
      plan_row_type r;
      r = '0;
      r.rq.kind = mali_pkg::KIND_TARGET;
      r.rq.goal = {l, m, t, w, a, b};
      return r;
   endfunction

   function automatic plan_row_type tick_row();
      plan_row_type r;
      r = '0;
      r.rq.kind = mali_pkg::KIND_TICK;
      return r;
   endfunction

   function automatic plan_row_type known(input plan_row_type r,
                                          input logic [8:0] b, a, w, t, m, l,
                                          input logic mv, input logic ar);
      plan_row_type k;
      k = r;
      k.known_rsp = 1'b1;
      k.rsp.pos = {l, m, t, w, a, b};
      k.rsp.moving = mv;
      k.rsp.arrived = ar;
      return k;
   endfunction

   // Pick the next random transaction; mostly complete moves with small steps
   function automatic motion_req_type next_motion();
      motion_req_type rq;
      int roll;
      int span;
      int g;
      roll = $urandom_range(0, 99);
      rq.kind = mali_pkg::KIND_TICK;
      rq.goal = 54'({$urandom, $urandom});
      if (steps_done < move_len) begin
         if (roll < 90) return rq;
         rq.kind = mali_pkg::KIND_TARGET;
         if (roll < 95) return rq;
      end else begin
         if (roll < 10) return rq;
         rq.kind = mali_pkg::KIND_TARGET;
         if (roll < 20) return rq;
      end
      // Nearby target: short move, sometimes equal to the present pose
      span = ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 60))
                                         : int'($urandom_range(0, 5));
      for (int i = 0; i < AXES; i++) begin
         g = cur_ang[i] + int'($urandom_range(0, 2 * span)) - span;
         if (g < 0) g = 0;
         if (g > 511) g = 511;
         rq.goal[i] = g[8:0];
      end
      return rq;
   endfunction

   // Insert a random gap between bursts of back-to-back transactions
   task automatic pace_sender();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : int'($urandom_range(1, 30));
      end
      burst_left--;
   endtask

   // Offer one transaction at a falling edge and hold it until accepted
   task automatic offer(input plan_row_type row);
      pose_rsp_type want;
      req_kind <= row.rq.kind;
      req_goal_base <= row.rq.goal[0];
      req_goal_arm <= row.rq.goal[1];
      req_goal_wrist <= row.rq.goal[2];
      req_goal_top <= row.rq.goal[3];
      req_goal_middle <= row.rq.goal[4];
      req_goal_lower <= row.rq.goal[5];
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_pose(row.rq, want);
      pose_q.push_back(row.known_rsp ? row.rsp : want);
      @(negedge clock);
   endtask

   // Stimulus: directed table, then random moves
   initial begin
      plan_row_type dir_tab [$];
      plan_row_type row;
      for (int i = 0; i < AXES; i++) begin
         start_ang[i] = mali_pkg::HOME_ANGLE[i];
         goal_ang[i] = mali_pkg::HOME_ANGLE[i];
         cur_ang[i] = mali_pkg::HOME_ANGLE[i];
      end
      steps_done = 0;
      move_len = 0;

      // Tick while idle, target equal to pose, short move, extremes, restarts
      dir_tab.push_back(known(tick_row(), 90, 90, 90, 74, 158, 180, 1'b0, 1'b0));
      dir_tab.push_back(known(tgt(90, 90, 90, 74, 158, 180), 90, 90, 90, 74, 158, 180,
                              1'b0, 1'b1));
      dir_tab.push_back(known(tgt(92, 90, 90, 74, 158, 180), 90, 90, 90, 74, 158, 180,
                              1'b1, 1'b0));
      dir_tab.push_back(tick_row());
      dir_tab.push_back(tick_row());
      dir_tab.push_back(tick_row());
      dir_tab.push_back(tgt(0, 0, 0, 0, 0, 0));
      dir_tab.push_back(tick_row());
      dir_tab.push_back(tick_row());
      dir_tab.push_back(tgt(511, 511, 511, 511, 511, 511));
      dir_tab.push_back(tick_row());
      dir_tab.push_back(tick_row());
      dir_tab.push_back(tgt(511, 0, 511, 0, 511, 0));
      dir_tab.push_back(tick_row());
      dir_tab.push_back(tick_row());
      dir_tab.push_back(tick_row());
      dir_tab.push_back(tgt(0, 511, 0, 511, 0, 511));
      dir_tab.push_back(tick_row());
      dir_tab.push_back(tick_row());

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_tab[n]) begin
         pace_sender();
         offer(dir_tab[n]);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Starve the output for a while so the input backs up
         if (n == 200) hold_asks++;
         // Pause until the block has drained completely
         if (n == 350) begin
            req_valid <= 1'b0;
            wait (pose_q.size() == 0);
            @(negedge clock);
         end
         pace_sender();
         row = '0;
         row.rq = next_motion();
         offer(row);
      end

      req_valid <= 1'b0;
      wait (pose_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Receiver: rotate through stall patterns, plus one long hold-off on request
   rx_mode_type rx_mode = RX_OPEN;
   int mode_left = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int rx_cycles = 0;

   always @(negedge clock) begin
      rx_cycles++;
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= ((rx_cycles % 7) < 4);
         endcase
      end
   end

   function automatic string axis_name(input int i);
      case (i)
         0: return "pos_base";
         1: return "pos_arm";
         2: return "pos_wrist";
         3: return "pos_top";
         4: return "pos_middle";
         default: return "pos_lower";
      endcase
   endfunction

   // Compare each result transaction with the oldest expected pose
   always @(posedge clock) begin
      pose_rsp_type got;
      pose_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.pos = {rsp_pos_lower, rsp_pos_middle, rsp_pos_top,
                    rsp_pos_wrist, rsp_pos_arm, rsp_pos_base};
         got.moving = rsp_moving;
         got.arrived = rsp_arrived;
         if (pose_q.size() == 0) begin
            $error("unexpected result transaction");
            mismatches++;
         end else begin
            want = pose_q.pop_front();
            for (int i = 0; i < AXES; i++) begin
               if (got.pos[i] !== want.pos[i]) begin
                  $error("%s: expected %0d, actual %0d", axis_name(i), want.pos[i], got.pos[i]);
                  mismatches++;
               end
            end
            if (got.moving !== want.moving) begin
               $error("moving: expected %0d, actual %0d", want.moving, got.moving);
               mismatches++;
            end
            if (got.arrived !== want.arrived) begin
               $error("arrived: expected %0d, actual %0d", want.arrived, got.arrived);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule
